// ----- rtl/core/fsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared constants, signature tables and types for the filesystem
// signature probe.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // Probe window and offset counter sizing
  localparam int WINDOW_BYTES = 66560;
  localparam int OFF_W        = $clog2(WINDOW_BYTES + 1);
  localparam int POS_W        = 17;
  localparam int CMP_W        = (OFF_W > POS_W) ? OFF_W : POS_W;

  // Signature table: each pattern is left aligned in PAT_W bits
  localparam int SIG_COUNT = 14;
  localparam int PAT_W     = 80;
  localparam int LEN_W     = 4;

  localparam int SIG_NTFS   = 0;
  localparam int SIG_EXFAT  = 1;
  localparam int SIG_FAT32  = 2;
  localparam int SIG_FAT12  = 3;
  localparam int SIG_FAT16  = 4;
  localparam int SIG_FAT    = 5;
  localparam int SIG_BOOT   = 6;
  localparam int SIG_EXT    = 7;
  localparam int SIG_BTRFS  = 8;
  localparam int SIG_XFS    = 9;
  localparam int SIG_LUKS   = 10;
  localparam int SIG_ISO    = 11;
  localparam int SIG_SWAP_A = 12;
  localparam int SIG_SWAP_B = 13;

  localparam logic [POS_W-1:0] SIG_AT [SIG_COUNT] = '{
    17'd3, 17'd3, 17'd82, 17'd54, 17'd54, 17'd54, 17'd510, 17'd1080,
    17'h10040, 17'd0, 17'd0, 17'd32769, 17'd4086, 17'd4086
  };

  localparam logic [LEN_W-1:0] SIG_LEN [SIG_COUNT] = '{
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd2, 4'd2,
    4'd8, 4'd4, 4'd6, 4'd5, 4'd10, 4'd10
  };

  // btrfs magic is given as raw ASCII bytes
  localparam logic [PAT_W-1:0] SIG_PAT [SIG_COUNT] = '{
    {"NTFS    ", 16'h0000},
    {"EXFAT   ", 16'h0000},
    {"FAT32   ", 16'h0000},
    {"FAT12   ", 16'h0000},
    {"FAT16   ", 16'h0000},
    {"FAT     ", 16'h0000},
    {8'h55, 8'hAA, 64'h0},
    {8'h53, 8'hEF, 64'h0},
    {64'h5F42_4852_6653_5F4D, 16'h0000},
    {"XFSB", 48'h0},
    {"LUKS", 8'hBA, 8'hBE, 32'h0},
    {"CD001", 40'h0},
    {"SWAPSPACE2"},
    {"SWAP-SPACE"}
  };

  // ext superblock feature bytes
  localparam logic [POS_W-1:0] EXT_COMPAT_OFF  = 17'd1116;
  localparam logic [POS_W-1:0] EXT_INCOMPAT_LO = 17'd1120;
  localparam logic [POS_W-1:0] EXT_INCOMPAT_HI = 17'd1121;
  localparam logic [7:0]       EXT_JOURNAL_MSK = 8'h04;
  localparam logic [7:0]       EXT_EXTENTS_MSK = 8'h40;
  localparam logic [7:0]       EXT_64BIT_MSK   = 8'h02;

  localparam int EXT_JOURNAL = 0;
  localparam int EXT_EXTENTS = 1;
  localparam int EXT_64BIT   = 2;

  // Result codes
  localparam logic [3:0] KIND_UNKNOWN = 4'd0;
  localparam logic [3:0] KIND_NTFS    = 4'd1;
  localparam logic [3:0] KIND_EXFAT   = 4'd2;
  localparam logic [3:0] KIND_FAT32   = 4'd3;
  localparam logic [3:0] KIND_FAT1X   = 4'd4;
  localparam logic [3:0] KIND_EXT4    = 4'd5;
  localparam logic [3:0] KIND_EXT3    = 4'd6;
  localparam logic [3:0] KIND_EXT2    = 4'd7;
  localparam logic [3:0] KIND_BTRFS   = 4'd8;
  localparam logic [3:0] KIND_XFS     = 4'd9;
  localparam logic [3:0] KIND_LUKS    = 4'd10;
  localparam logic [3:0] KIND_ISO     = 4'd11;
  localparam logic [3:0] KIND_SWAP    = 4'd12;
  localparam logic [3:0] KIND_MBR     = 4'd13;

  localparam logic [1:0] NOTE_NONE    = 2'd0;
  localparam logic [1:0] NOTE_EXTENTS = 2'd1;
  localparam logic [1:0] NOTE_64BIT   = 2'd2;
  localparam logic [1:0] NOTE_JOURNAL = 2'd3;

  typedef logic [OFF_W-1:0] fsp_off_t;

  // Per-byte match outcome
  typedef struct packed {
    logic [SIG_COUNT-1:0] miss;
    logic [2:0]           ext_set;
  } fsp_match_t;

  // Final verdict
  typedef struct packed {
    logic [3:0] fs_kind;
    logic [1:0] note;
  } fsp_result_t;

endpackage

// ----- rtl/core/fsp_sig_match.sv -----
// ----------------------------------------------------------------------------
// fsp_sig_match
// Compares one byte against every signature that covers its offset and
// picks up the ext feature bits.
// ----------------------------------------------------------------------------
module fsp_sig_match import fsp_pkg::*; (
  input  fsp_off_t   off,
  input  logic [7:0] data_byte,
  output fsp_match_t match
);

  logic [CMP_W-1:0] off_x;
  logic [CMP_W-1:0] rel     [SIG_COUNT];
  logic [PAT_W-1:0] shifted [SIG_COUNT];
  logic [SIG_COUNT-1:0] in_rng;

  // Per-signature range check, expected byte lookup and ext feature taps
  always_comb begin
    off_x = CMP_W'(off);
    for (int i = 0; i < SIG_COUNT; i++) begin
      rel[i]     = off_x - CMP_W'(SIG_AT[i]);
      in_rng[i]  = (off_x >= CMP_W'(SIG_AT[i])) && (rel[i] < CMP_W'(SIG_LEN[i]));
      shifted[i] = SIG_PAT[i] << {rel[i][3:0], 3'b000};
      match.miss[i] = in_rng[i] && (data_byte != shifted[i][PAT_W-1 -: 8]);
    end
    match.ext_set[EXT_JOURNAL] = (off_x == CMP_W'(EXT_COMPAT_OFF)) &&
                                 ((data_byte & EXT_JOURNAL_MSK) != 8'h00);
    match.ext_set[EXT_EXTENTS] = (off_x == CMP_W'(EXT_INCOMPAT_LO)) &&
                                 ((data_byte & EXT_EXTENTS_MSK) != 8'h00);
    match.ext_set[EXT_64BIT]   = (off_x == CMP_W'(EXT_INCOMPAT_HI)) &&
                                 ((data_byte & EXT_64BIT_MSK) != 8'h00);
  end

endmodule

// ----- rtl/core/fsp_verdict.sv -----
// ----------------------------------------------------------------------------
// fsp_verdict
// Turns the candidate flags, byte count and ext bits of a finished window
// into a filesystem kind and feature note.
// ----------------------------------------------------------------------------
module fsp_verdict import fsp_pkg::*; (
  input  logic [SIG_COUNT-1:0] flags,
  input  fsp_off_t             off,
  input  logic [2:0]           ext_bits,
  output fsp_result_t          result
);

  logic [SIG_COUNT-1:0] hit;

  // A signature hits only if it survived and all its bytes arrived
  always_comb begin
    for (int i = 0; i < SIG_COUNT; i++) begin
      hit[i] = flags[i] &&
               (CMP_W'(off) >= (CMP_W'(SIG_AT[i]) + CMP_W'(SIG_LEN[i])));
    end
  end

  // Priority order
  always_comb begin
    result.fs_kind = KIND_UNKNOWN;
    result.note    = NOTE_NONE;
    if (hit[SIG_BOOT] && hit[SIG_NTFS]) begin
      result.fs_kind = KIND_NTFS;
    end else if (hit[SIG_BOOT] && hit[SIG_EXFAT]) begin
      result.fs_kind = KIND_EXFAT;
    end else if (hit[SIG_FAT32]) begin
      result.fs_kind = KIND_FAT32;
    end else if (hit[SIG_FAT12] || hit[SIG_FAT16] || hit[SIG_FAT]) begin
      result.fs_kind = KIND_FAT1X;
    end else if (hit[SIG_EXT]) begin
      if (ext_bits[EXT_EXTENTS] || ext_bits[EXT_64BIT]) begin
        result.fs_kind = KIND_EXT4;
        result.note    = ext_bits[EXT_EXTENTS] ? NOTE_EXTENTS : NOTE_64BIT;
      end else if (ext_bits[EXT_JOURNAL]) begin
        result.fs_kind = KIND_EXT3;
        result.note    = NOTE_JOURNAL;
      end else begin
        result.fs_kind = KIND_EXT2;
      end
    end else if (hit[SIG_BTRFS]) begin
      result.fs_kind = KIND_BTRFS;
    end else if (hit[SIG_XFS]) begin
      result.fs_kind = KIND_XFS;
    end else if (hit[SIG_LUKS]) begin
      result.fs_kind = KIND_LUKS;
    end else if (hit[SIG_ISO]) begin
      result.fs_kind = KIND_ISO;
    end else if (hit[SIG_SWAP_A] || hit[SIG_SWAP_B]) begin
      result.fs_kind = KIND_SWAP;
    end else if (hit[SIG_BOOT]) begin
      result.fs_kind = KIND_MBR;
    end
  end

endmodule

// ----- rtl/core/filesystem_signature_probe.sv -----
// ----------------------------------------------------------------------------
// filesystem_signature_probe
// Streams the leading bytes of a disk image and reports the filesystem kind.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one disk byte per request, from
//   offset zero upward. in_last_byte marks the final byte of the window.
//   Output channel (out_valid / out_stall): one request per window, carrying
//   out_fs_kind and out_feature_note, issued for the byte marked last.
//   Bytes beyond WINDOW_BYTES are ignored; the offset counter saturates.
// Timing:
//   A byte is registered on acceptance; ordinary bytes are folded into the
//   signature state the next cycle, a last byte when the result slot frees
//   and out_valid is registered. One byte per cycle unless a last byte waits;
//   the single update stage sits between input register and result register.
// Reset:
//   rst_n (synchronous, active low) clears both valids and starts a new
//   window at offset zero. After each result the state returns there too.
// Stall:
//   A held result stalls only a following last byte; ordinary bytes keep
//   flowing while the result waits.
// ----------------------------------------------------------------------------
module filesystem_signature_probe import fsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_fs_kind,
  output logic [1:0] out_feature_note
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_data_r;
  logic                 s1_last_r;
  fsp_off_t             off_r, off_nxt, off_upd;
  logic [SIG_COUNT-1:0] flags_r, flags_nxt, flags_upd;
  logic [2:0]           ext_r, ext_nxt, ext_upd;
  logic                 out_valid_r, out_valid_nxt;
  logic [3:0]           out_fs_kind_r;
  logic [1:0]           out_note_r;

  logic        s1_fire;
  logic        in_take;
  logic        in_window;
  fsp_match_t  match;
  fsp_result_t result;

  // Handshake: a last byte waits only while the result slot is held
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Signature compare for the registered byte
  fsp_sig_match u_match (
    .off       (off_r),
    .data_byte (s1_data_r),
    .match     (match)
  );

  // State update inside the window
  assign in_window = off_r < OFF_W'(WINDOW_BYTES);
  assign off_upd   = in_window ? off_r + OFF_W'(1) : off_r;
  assign flags_upd = in_window ? (flags_r & ~match.miss) : flags_r;
  assign ext_upd   = in_window ? (ext_r | match.ext_set) : ext_r;

  // Verdict on the updated state
  fsp_verdict u_verdict (
    .flags    (flags_upd),
    .off      (off_upd),
    .ext_bits (ext_upd),
    .result   (result)
  );

  // Next window state: a last byte restarts the probe
  always_comb begin
    off_nxt   = off_r;
    flags_nxt = flags_r;
    ext_nxt   = ext_r;
    if (s1_fire) begin
      if (s1_last_r) begin
        off_nxt   = '0;
        flags_nxt = '1;
        ext_nxt   = '0;
      end else begin
        off_nxt   = off_upd;
        flags_nxt = flags_upd;
        ext_nxt   = ext_upd;
      end
    end
  end

  // Result slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      off_r       <= '0;
      flags_r     <= '1;
      ext_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      off_r       <= off_nxt;
      flags_r     <= flags_nxt;
      ext_r       <= ext_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_fire && s1_last_r) begin
      out_fs_kind_r <= result.fs_kind;
      out_note_r    <= result.note;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fs_kind      = out_fs_kind_r;
  assign out_feature_note = out_note_r;

  // Checks
  a_note_ext_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_note_r == NOTE_NONE || out_fs_kind_r == KIND_EXT4 ||
                     out_fs_kind_r == KIND_EXT3 || out_fs_kind_r == KIND_EXT2))
    else $error("feature note on a non-ext result");

  a_off_sat: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(off_r) <= CMP_W'(WINDOW_BYTES))
    else $error("offset counter past window");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (off_r == '0 && flags_r == '1 && ext_r == '0))
    else $error("probe state not cleared after result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a held result");

endmodule
